// ----- hdl/jls_pkg.sv -----
// jls_pkg: shared types and codes for the jacobi linear solver
// request, status and register codes, channel payloads, controller command/status groups
// no dependencies
package jls_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD_MAT = 2'd0,
		REQ_LOAD_RHS = 2'd1,
		REQ_START    = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_CONVERGED = 2'd0,
		ST_LIMIT     = 2'd1,
		ST_ZERO_DIAG = 2'd2,
		ST_SPARE     = 2'd3
	} status_t;

	typedef enum logic {
		CFG_STOP_THRESHOLD = 1'b0,
		CFG_MAX_ITERATIONS = 1'b1
	} cfg_idx_t;

	localparam int CfgW = 31;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         index;
		logic signed [31:0] solution;
		logic               last;
		logic [1:0]         status;
		logic [15:0]        sweeps;
	} out_item_t;

	typedef struct packed {
		logic wr_mat;
		logic wr_rhs;
		logic chk;
		logic zd_clr;
		logic mac_en;
		logic mac_diag;
		logic x_zero;
		logic rhs_rd;
		logic acc_clr;
		logic worst_clr;
		logic div_start;
		logic upd;
		logic out_load;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic div_busy;
		logic zdiag;
		logic conv;
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/jls_if.sv -----
// jls_in_if, jls_out_if: valid/ready channels of the jacobi linear solver
// depends on jls_pkg for the payload types
interface jls_in_if import jls_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jls_out_if import jls_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/jls_datapath.sv -----
// jls_datapath: coefficient, right-hand and guess memories, multiply-accumulate,
// serial divider, update and output register of the jacobi linear solver
// depends on jls_pkg
module jls_datapath import jls_pkg::*; #(
	parameter int ORDER = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmd_t                             cmd,
	output stat_t                            stat,
	input  logic [$clog2(ORDER*ORDER)-1:0]   mat_addr,
	input  logic [$clog2(ORDER)-1:0]         rhs_addr,
	input  logic [$clog2(ORDER):0]           x_raddr,
	input  logic [$clog2(ORDER):0]           x_waddr,
	input  logic signed [31:0]               ld_value,
	input  logic [CfgW-1:0]                  thr,
	input  logic [3:0]                       o_index,
	input  logic [1:0]                       o_status,
	input  logic [15:0]                      o_sweeps,
	output logic                             o_valid,
	input  logic                             o_ready,
	output out_item_t                        o_data
);
	localparam int IW   = $clog2(ORDER);
	localparam int ACCW = 48 + IW + 1;
	localparam int RW   = ACCW + 1;
	localparam logic signed [RW-1:0] QHI = {{(RW-47){1'b0}}, 1'b1, 46'd0};
	localparam logic signed [RW-1:0] QLO = -QHI;

	logic signed [31:0] mat_mem [ORDER*ORDER];
	logic signed [31:0] rhs_mem [ORDER];
	logic signed [31:0] x_mem   [2**(IW+1)];

	logic signed [31:0] a_s1, xr_s1, b_q, diag_q, xi_q;
	logic               v_s1, diag_s1, chk_s1, xz_s1, v_s2, zdiag_q;
	logic signed [63:0] prod_s2;
	logic signed [ACCW-1:0] acc_q;
	logic signed [31:0] xval;

	logic [62:0] dq_q;
	logic [31:0] rem_q, den_q;
	logic [5:0]  dcnt_q;
	logic        dbusy_q, dneg_q;
	logic [32:0] worst_q;

	logic signed [RW-1:0] r_full;
	logic signed [47:0]   r_c;
	logic [46:0]          r_mag;
	logic [32:0]          rem_sh;
	logic                 ge;
	logic signed [63:0]   q64;
	logic signed [64:0]   diff;
	logic signed [31:0]   nx;
	logic signed [32:0]   dlt;
	logic [32:0]          dabs;

	assign xval = xz_s1 ? 32'sd0 : xr_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_mat) mat_mem[mat_addr] <= ld_value;
		if (cmd.wr_rhs) rhs_mem[rhs_addr] <= ld_value;
		if (cmd.upd) x_mem[x_waddr] <= nx;
		a_s1  <= mat_mem[mat_addr];
		xr_s1 <= x_mem[x_raddr];
		xz_s1 <= cmd.x_zero;
		if (cmd.rhs_rd) b_q <= rhs_mem[rhs_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			chk_s1  <= 1'b0;
			v_s2    <= 1'b0;
			zdiag_q <= 1'b0;
			dbusy_q <= 1'b0;
			o_valid <= 1'b0;
		end else begin
			v_s1   <= cmd.mac_en;
			chk_s1 <= cmd.chk;
			v_s2   <= v_s1;
			if (cmd.zd_clr) zdiag_q <= 1'b0;
			else if (chk_s1 && a_s1 == 32'sd0) zdiag_q <= 1'b1;
			if (cmd.div_start) dbusy_q <= 1'b1;
			else if (dbusy_q && dcnt_q == 6'd0) dbusy_q <= 1'b0;
			if (cmd.out_load) o_valid <= 1'b1;
			else if (o_ready) o_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		diag_s1 <= cmd.mac_diag;
		if (v_s1 && diag_s1) begin
			diag_q <= a_s1;
			xi_q   <= xval;
		end
		prod_s2 <= a_s1 * xval;
		if (cmd.acc_clr) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + ACCW'(signed'(prod_s2[63:16]));
	end

	// residual, clamp and magnitudes for the divider
	always_comb begin
		r_full = RW'(acc_q) - RW'(b_q);
		if (r_full > QHI) r_c = 48'(QHI);
		else if (r_full < QLO) r_c = 48'(QLO);
		else r_c = 48'(r_full);
		r_mag  = r_c[47] ? 47'(-r_c) : 47'(r_c);
		rem_sh = {rem_q, dq_q[62]};
		ge     = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q   <= {r_mag, 16'd0};
			rem_q  <= '0;
			den_q  <= diag_q[31] ? 32'(-diag_q) : 32'(diag_q);
			dneg_q <= r_c[47] ^ diag_q[31];
			dcnt_q <= 6'd62;
		end else if (dbusy_q) begin
			rem_q  <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			dq_q   <= {dq_q[61:0], ge};
			dcnt_q <= dcnt_q - 6'd1;
		end
	end

	// new element, saturation and change
	always_comb begin
		q64  = dneg_q ? -signed'({1'b0, dq_q}) : signed'({1'b0, dq_q});
		diff = 65'(xi_q) - 65'(q64);
		if (diff > 65'sh0_7FFF_FFFF) nx = 32'sh7FFF_FFFF;
		else if (diff < -65'sh0_8000_0000) nx = -32'sh8000_0000;
		else nx = 32'(diff);
		dlt  = 33'(nx) - 33'(xi_q);
		dabs = dlt[32] ? 33'(-dlt) : 33'(dlt);
	end

	always_ff @(posedge clk) begin
		if (cmd.worst_clr) worst_q <= '0;
		else if (cmd.upd && dabs > worst_q) worst_q <= dabs;
		if (cmd.out_load) begin
			o_data.index    <= o_index;
			o_data.solution <= xval;
			o_data.last     <= cmd.out_last;
			o_data.status   <= o_status;
			o_data.sweeps   <= o_sweeps;
		end
	end

	assign stat.busy     = v_s1 | v_s2 | chk_s1;
	assign stat.div_busy = dbusy_q;
	assign stat.zdiag    = zdiag_q;
	assign stat.conv     = worst_q <= {2'b00, thr};
	assign stat.out_free = !o_valid || o_ready;

endmodule

// ----- hdl/jls_ctrl.sv -----
// jls_ctrl: sequencer of the jacobi linear solver
// decodes requests, steps rows, columns, sweeps and output elements
// depends on jls_pkg
module jls_ctrl import jls_pkg::*; #(
	parameter int ORDER = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  in_item_t                         in_data,
	input  logic [15:0]                      max_iter,
	input  stat_t                            stat,
	output cmd_t                             cmd,
	output logic [$clog2(ORDER*ORDER)-1:0]   mat_addr,
	output logic [$clog2(ORDER)-1:0]         rhs_addr,
	output logic [$clog2(ORDER):0]           x_raddr,
	output logic [$clog2(ORDER):0]           x_waddr,
	output logic [3:0]                       o_index,
	output logic [1:0]                       o_status,
	output logic [15:0]                      o_sweeps
);
	localparam int AW = $clog2(ORDER*ORDER);
	localparam int IW = $clog2(ORDER);
	localparam logic [IW-1:0] LASTI = IW'(ORDER - 1);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_ZCHK  = 12'b0000_0000_0010,
		S_ZWAIT = 12'b0000_0000_0100,
		S_ROWB  = 12'b0000_0000_1000,
		S_MAC   = 12'b0000_0001_0000,
		S_DRAIN = 12'b0000_0010_0000,
		S_DIVL  = 12'b0000_0100_0000,
		S_DIVW  = 12'b0000_1000_0000,
		S_UPD   = 12'b0001_0000_0000,
		S_SEND  = 12'b0010_0000_0000,
		S_OUTRD = 12'b0100_0000_0000,
		S_OUTLD = 12'b1000_0000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic          bank_q, bank_d, first_q, first_d;
	logic [15:0]   cnt_q, cnt_d, cnt_inc;
	status_t       st_q, st_d;
	logic          accept, row_ok, col_ok;
	logic [IW-1:0] ar, ac;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign row_ok   = {1'b0, in_data.row} < 5'(ORDER);
	assign col_ok   = {1'b0, in_data.col} < 5'(ORDER);
	assign cnt_inc  = cnt_q + 16'd1;

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		bank_d  = bank_q;
		first_d = first_q;
		cnt_d   = cnt_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.x_zero = first_q;
		ar       = i_q;
		ac       = j_q;
		rhs_addr = i_q;
		x_raddr  = {bank_q, j_q};
		unique case (state_q)
			S_IDLE: begin
				ar       = IW'(in_data.row);
				ac       = IW'(in_data.col);
				rhs_addr = IW'(in_data.row);
				if (accept) begin
					case (in_data.req_type)
						REQ_LOAD_MAT: cmd.wr_mat = row_ok && col_ok;
						REQ_LOAD_RHS: cmd.wr_rhs = row_ok;
						REQ_START: begin
							cmd.zd_clr = 1'b1;
							first_d    = 1'b1;
							cnt_d      = '0;
							i_d        = '0;
							state_d    = S_ZCHK;
						end
						default: ;
					endcase
				end
			end
			S_ZCHK: begin
				ac      = i_q;
				cmd.chk = 1'b1;
				if (i_q == LASTI) begin
					i_d     = '0;
					state_d = S_ZWAIT;
				end else begin
					i_d = i_q + IW'(1);
				end
			end
			S_ZWAIT: begin
				if (!stat.busy) begin
					cmd.worst_clr = 1'b1;
					if (stat.zdiag) begin
						st_d    = ST_ZERO_DIAG;
						k_d     = '0;
						state_d = S_OUTRD;
					end else begin
						state_d = S_ROWB;
					end
				end
			end
			S_ROWB: begin
				cmd.rhs_rd  = 1'b1;
				cmd.acc_clr = 1'b1;
				j_d         = '0;
				state_d     = S_MAC;
			end
			S_MAC: begin
				cmd.mac_en   = 1'b1;
				cmd.mac_diag = j_q == i_q;
				if (j_q == LASTI) state_d = S_DRAIN;
				else j_d = j_q + IW'(1);
			end
			S_DRAIN: begin
				if (!stat.busy) state_d = S_DIVL;
			end
			S_DIVL: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (!stat.div_busy) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (i_q == LASTI) begin
					i_d     = '0;
					state_d = S_SEND;
				end else begin
					i_d     = i_q + IW'(1);
					state_d = S_ROWB;
				end
			end
			S_SEND: begin
				cnt_d         = cnt_inc;
				bank_d        = !bank_q;
				first_d       = 1'b0;
				cmd.worst_clr = 1'b1;
				k_d           = '0;
				if (stat.conv) begin
					st_d    = ST_CONVERGED;
					state_d = S_OUTRD;
				end else if (cnt_inc >= max_iter) begin
					st_d    = ST_LIMIT;
					state_d = S_OUTRD;
				end else begin
					state_d = S_ROWB;
				end
			end
			S_OUTRD: begin
				x_raddr = {bank_q, k_q};
				if (stat.out_free) state_d = S_OUTLD;
			end
			S_OUTLD: begin
				cmd.out_load = 1'b1;
				cmd.out_last = k_q == LASTI;
				if (k_q == LASTI) begin
					state_d = S_IDLE;
				end else begin
					k_d     = k_q + IW'(1);
					state_d = S_OUTRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign mat_addr = AW'(ar) * AW'(ORDER) + AW'(ac);
	assign x_waddr  = {!bank_q, i_q};
	assign o_index  = 4'(k_q);
	assign o_status = st_q;
	assign o_sweeps = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			bank_q  <= 1'b0;
			first_q <= 1'b1;
			cnt_q   <= '0;
			st_q    <= ST_CONVERGED;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			bank_q  <= bank_d;
			first_q <= first_d;
			cnt_q   <= cnt_d;
			st_q    <= st_d;
		end
	end

endmodule

// ----- hdl/jacobi_linear_solver.sv -----
// jacobi_linear_solver: top level, configuration registers and channel wiring
// depends on jls_pkg, jls_if, jls_ctrl, jls_datapath
//
// channel   role    carries
// in_ch     sink    load matrix element, load right-hand element, start solve
// out_ch    source  one solution element per transaction, ORDER per run
// cfg_*     write   stop_threshold (index 0), max_iterations (index 1)
//
// ready is high only while the sequencer is idle
// a solve first checks every diagonal element for zero after the start transaction,
// then runs sweeps of row multiply-accumulate, a 63-step serial divide and update per row
// results leave through an output register; a stalled sink holds the sequencer
// reset clears control state and restores the register defaults; no clearing pass
module jacobi_linear_solver import jls_pkg::*; #(
	parameter int ORDER = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	jls_in_if.sink            in_ch,
	jls_out_if.source         out_ch,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CfgW-1:0]   cfg_data
);
	localparam int AW = $clog2(ORDER*ORDER);
	localparam int IW = $clog2(ORDER);

	logic [CfgW-1:0] thr_q;
	logic [15:0]     max_q;
	cmd_t            cmd;
	stat_t           stat;
	logic [AW-1:0]   mat_addr;
	logic [IW-1:0]   rhs_addr;
	logic [IW:0]     x_raddr, x_waddr;
	logic [3:0]      o_index;
	logic [1:0]      o_status;
	logic [15:0]     o_sweeps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= CfgW'(7);
			max_q <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_STOP_THRESHOLD: thr_q <= cfg_data;
				CFG_MAX_ITERATIONS: max_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	jls_ctrl #(.ORDER(ORDER)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_data  (in_ch.data),
		.max_iter (max_q),
		.stat     (stat),
		.cmd      (cmd),
		.mat_addr (mat_addr),
		.rhs_addr (rhs_addr),
		.x_raddr  (x_raddr),
		.x_waddr  (x_waddr),
		.o_index  (o_index),
		.o_status (o_status),
		.o_sweeps (o_sweeps)
	);

	jls_datapath #(.ORDER(ORDER)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.mat_addr (mat_addr),
		.rhs_addr (rhs_addr),
		.x_raddr  (x_raddr),
		.x_waddr  (x_waddr),
		.ld_value (in_ch.data.value),
		.thr      (thr_q),
		.o_index  (o_index),
		.o_status (o_status),
		.o_sweeps (o_sweeps),
		.o_valid  (out_ch.valid),
		.o_ready  (out_ch.ready),
		.o_data   (out_ch.data)
	);

endmodule
